// ----- design/hmpd_pkg.sv -----
// shared types and constants for the hold-and-modify pixel decoder
package hmpd_pkg;

  localparam int unsigned PixelsPerItem = 8;
  localparam int unsigned PixCntW       = $clog2(PixelsPerItem);
  localparam int unsigned TableDepth    = 16;
  localparam int unsigned IdxW          = $clog2(TableDepth);

  typedef enum logic {
    FuncWrite  = 1'b0,
    FuncDecode = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    CtlLoad  = 2'd0,
    CtlBlue  = 2'd1,
    CtlRed   = 2'd2,
    CtlGreen = 2'd3
  } ctl_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] p3;
    logic [7:0] p4;
    logic [7:0] p5;
  } planes_t;

  // item held at the head of the block
  typedef struct packed {
    func_e         func;
    logic          frame_start;
    logic [IdxW-1:0] entry_index;
    rgb_t          entry;
    planes_t       planes;
  } item_t;

  // decode request from the head register to the pixel unit
  typedef struct packed {
    logic    valid;
    logic    frame_start;
    planes_t planes;
  } pix_req_t;

endpackage

// ----- design/hmpd_palette.sv -----
// 16-entry colour table, one write port and one read port
module hmpd_palette import hmpd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  rgb_t            wr_data_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output rgb_t            rd_data_o
);

  rgb_t table_q [TableDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableDepth; i++) begin
        table_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      table_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign rd_data_o = table_q[rd_idx_i];

endmodule

// ----- design/hmpd_pixel.sv -----
// per-pixel hold-and-modify update, held colour and result register
module hmpd_pixel import hmpd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pix_req_t        req_i,
  output logic            done_o,
  output logic [IdxW-1:0] pal_idx_o,
  input  rgb_t            pal_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rgb_t            out_rgb_o,
  output logic            out_last_o
);

  logic [PixCntW-1:0] pix_q;
  rgb_t               held_q, held_d;
  logic               out_valid_q;
  logic               last_q;
  logic [PixCntW-1:0] pos;
  logic [IdxW-1:0]    idx;
  ctl_e               ctl;
  logic [7:0]         level;
  rgb_t               base;
  logic               step;
  logic               at_last;

  // msb first: pixel k uses bit 7-k
  assign pos   = ~pix_q;
  assign idx   = {req_i.planes.p3[pos], req_i.planes.p2[pos],
                  req_i.planes.p1[pos], req_i.planes.p0[pos]};
  assign ctl   = ctl_e'({req_i.planes.p5[pos], req_i.planes.p4[pos]});
  assign level = {idx, 4'h0};
  assign pal_idx_o = idx;

  assign at_last = (pix_q == PixCntW'(PixelsPerItem - 1));
  assign step    = req_i.valid && (!out_valid_q || out_ready_i);
  assign done_o  = step && at_last;

  always_comb begin
    // frame start clears the held colour ahead of the first pixel
    base   = (req_i.frame_start && (pix_q == '0)) ? '0 : held_q;
    held_d = base;
    unique case (ctl)
      CtlLoad:  held_d = pal_data_i;
      CtlBlue:  held_d.blue = level;
      CtlRed:   held_d.red = level;
      CtlGreen: held_d.green = level;
      default:  held_d = base;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else if (step) begin
      pix_q       <= pix_q + PixCntW'(1);
      held_q      <= held_d;
      out_valid_q <= 1'b1;
      last_q      <= at_last;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // the result register is the held colour itself
  assign out_valid_o = out_valid_q;
  assign out_rgb_o   = held_q;
  assign out_last_o  = last_q;

endmodule

// ----- design/hold_modify_pixel_decoder_unit.sv -----
// top level of the hold-and-modify pixel decoder
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_ready_o   | func, frame_start, entry_*, plane_*
//   out     | output    | out_valid_o / out_ready_i | out_red/green/blue, last_pixel
//
// a table-write item is written into the colour table from the head register and gives no transfer.
// a decode item gives eight pixels: the pixel unit emits one pixel per cycle into the
// result register while the output is not stalled, and the item retires with its last pixel.
// the next item is taken into the head register in the cycle the current one retires.
// reset clears the held colour, the colour table and all valid flags.
// a stalled output holds the result register and stops the pixel counter.
module hold_modify_pixel_decoder_unit import hmpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic       frame_start_i,
  input  logic [3:0] entry_index_i,
  input  logic [7:0] entry_red_i,
  input  logic [7:0] entry_green_i,
  input  logic [7:0] entry_blue_i,
  input  logic [7:0] plane_zero_i,
  input  logic [7:0] plane_one_i,
  input  logic [7:0] plane_two_i,
  input  logic [7:0] plane_three_i,
  input  logic [7:0] plane_four_i,
  input  logic [7:0] plane_five_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic       last_pixel_o
);

  item_t           item_q;
  logic            item_valid_q;
  logic            consume;
  logic            pal_we;
  logic            pix_done;
  logic [IdxW-1:0] pal_idx;
  rgb_t            pal_data;
  pix_req_t        pix_req;
  rgb_t            out_rgb;

  assign pal_we  = item_valid_q && (item_q.func == FuncWrite);
  assign consume = pal_we || pix_done;
  assign in_ready_o = !item_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.func         <= func_e'(func_i);
      item_q.frame_start  <= frame_start_i;
      item_q.entry_index  <= entry_index_i;
      item_q.entry        <= '{red: entry_red_i, green: entry_green_i, blue: entry_blue_i};
      item_q.planes       <= '{p0: plane_zero_i, p1: plane_one_i, p2: plane_two_i,
                               p3: plane_three_i, p4: plane_four_i, p5: plane_five_i};
    end
  end

  assign pix_req.valid       = item_valid_q && (item_q.func == FuncDecode);
  assign pix_req.frame_start = item_q.frame_start;
  assign pix_req.planes      = item_q.planes;

  hmpd_palette u_palette (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (pal_we),
    .wr_idx_i  (item_q.entry_index),
    .wr_data_i (item_q.entry),
    .rd_idx_i  (pal_idx),
    .rd_data_o (pal_data)
  );

  hmpd_pixel u_pixel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (pix_req),
    .done_o      (pix_done),
    .pal_idx_o   (pal_idx),
    .pal_data_i  (pal_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rgb_o   (out_rgb),
    .out_last_o  (last_pixel_o)
  );

  assign out_red_o   = out_rgb.red;
  assign out_green_o = out_rgb.green;
  assign out_blue_o  = out_rgb.blue;

  // an accepted item always lands in the head register
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> item_valid_q)
    else $error("accepted item not held");

  // a result only appears after a decode item was at the head
  a_out_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pix_req.valid))
    else $error("result without decode item");

  // retiring a decode item leaves its eighth pixel in the result register
  a_retire_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_done |=> out_valid_o && last_pixel_o)
    else $error("decode item retired without last pixel");

  // table writes and pixel steps never retire in the same cycle
  a_one_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pal_we && pix_done))
    else $error("two items retired at once");

endmodule

// ----- dv/tb_hold_modify_pixel_decoder_unit.sv -----
// testbench for the hold-and-modify pixel decoder: directed and random items, scoreboard
module tb_hold_modify_pixel_decoder_unit;
  import hmpd_pkg::*;

  localparam int StallLimit = 2000;
  localparam int SettleCycles = 20;
  localparam int RandomItems = 100;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready_o;
  logic       func_i = 1'b0;
  logic       frame_start_i = 1'b0;
  logic [3:0] entry_index_i = '0;
  logic [7:0] entry_red_i = '0;
  logic [7:0] entry_green_i = '0;
  logic [7:0] entry_blue_i = '0;
  logic [7:0] plane_zero_i = '0;
  logic [7:0] plane_one_i = '0;
  logic [7:0] plane_two_i = '0;
  logic [7:0] plane_three_i = '0;
  logic [7:0] plane_four_i = '0;
  logic [7:0] plane_five_i = '0;
  logic       out_valid_o;
  logic       out_ready = 1'b0;
  logic [7:0] out_red_o;
  logic [7:0] out_green_o;
  logic [7:0] out_blue_o;
  logic       last_pixel_o;

  // predictor state
  rgb_t   held_colour = '0;
  rgb_t   colour_table [TableDepth];
  pixel_t pixel_q [$];
  pixel_t want_px;

  int  mismatch_count = 0;
  int  pixel_count = 0;
  int  idle_cycles = 0;
  bit  fast_mode = 1'b0;

  hold_modify_pixel_decoder_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .frame_start_i (frame_start_i),
    .entry_index_i (entry_index_i),
    .entry_red_i   (entry_red_i),
    .entry_green_i (entry_green_i),
    .entry_blue_i  (entry_blue_i),
    .plane_zero_i  (plane_zero_i),
    .plane_one_i   (plane_one_i),
    .plane_two_i   (plane_two_i),
    .plane_three_i (plane_three_i),
    .plane_four_i  (plane_four_i),
    .plane_five_i  (plane_five_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .last_pixel_o  (last_pixel_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // update the colour table or decode eight pixels into the expected queue
  task automatic decode_item(input item_t it);
    logic [IdxW-1:0] idx;
    logic [7:0]      level;
    ctl_e            ctl;
    int              pos;
    if (it.func == FuncWrite) begin
      colour_table[it.entry_index] = it.entry;
    end else begin
      if (it.frame_start) held_colour = '0;
      for (int k = 0; k < PixelsPerItem; k++) begin
        pos   = PixelsPerItem - 1 - k;
        idx   = {it.planes.p3[pos], it.planes.p2[pos], it.planes.p1[pos], it.planes.p0[pos]};
        ctl   = ctl_e'({it.planes.p5[pos], it.planes.p4[pos]});
        level = {idx, 4'h0};
        case (ctl)
          CtlLoad:  held_colour = colour_table[idx];
          CtlBlue:  held_colour.blue = level;
          CtlRed:   held_colour.red = level;
          default:  held_colour.green = level;
        endcase
        pixel_q.push_back({held_colour.red, held_colour.green, held_colour.blue,
                           k == PixelsPerItem - 1});
      end
    end
  endtask

  function automatic item_t make_write(input logic [3:0] index, input logic [7:0] red,
                                       input logic [7:0] green, input logic [7:0] blue,
                                       input logic fs);
    item_t it;
    it.func        = FuncWrite;
    it.frame_start = fs;
    it.entry_index = index;
    it.entry       = {red, green, blue};
    it.planes      = 48'({$urandom, $urandom});
    return it;
  endfunction

  function automatic item_t make_decode(input logic fs, input logic [7:0] p0,
                                        input logic [7:0] p1, input logic [7:0] p2,
                                        input logic [7:0] p3, input logic [7:0] p4,
                                        input logic [7:0] p5);
    item_t       it;
    logic [23:0] junk;
    junk           = 24'($urandom);
    it.func        = FuncDecode;
    it.frame_start = fs;
    it.entry_index = 4'($urandom);
    it.entry       = junk;
    it.planes      = {p0, p1, p2, p3, p4, p5};
    return it;
  endfunction

  // valid is left high after the transfer; the next send or a drain decides
  task automatic send_item(input item_t it);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    func_i        <= it.func;
    frame_start_i <= it.frame_start;
    entry_index_i <= it.entry_index;
    entry_red_i   <= it.entry.red;
    entry_green_i <= it.entry.green;
    entry_blue_i  <= it.entry.blue;
    plane_zero_i  <= it.planes.p0;
    plane_one_i   <= it.planes.p1;
    plane_two_i   <= it.planes.p2;
    plane_three_i <= it.planes.p3;
    plane_four_i  <= it.planes.p4;
    plane_five_i  <= it.planes.p5;
    do @(posedge clk_i); while (!in_ready_o);
    decode_item(it);
  endtask

  // always waits on the clock before returning, so the next send drives in a later step
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pixel_q.size() != 0);
  endtask

  // table contents after reset are all zero
  task automatic test_reset_table();
    send_item(make_decode(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_decode(1'b0, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00));
  endtask

  // writes give no pixel; frame start on a write is ignored
  task automatic test_table_write();
    send_item(make_write(4'd0, 8'h12, 8'h34, 8'h56, 1'b1));
    send_item(make_write(4'd15, 8'hff, 8'hff, 8'hff, 1'b0));
    send_item(make_write(4'd9, 8'ha5, 8'h5a, 8'hc3, 1'b1));
    send_item(make_write(4'd6, 8'h00, 8'h80, 8'h01, 1'b0));
    send_item(make_decode(1'b0, 8'h66, 8'h55, 8'h55, 8'h66, 8'h00, 8'h00));
  endtask

  task automatic test_each_control();
    send_item(make_decode(1'b0, 8'h0f, 8'h33, 8'h55, 8'hf0, 8'hff, 8'h00));
    send_item(make_decode(1'b0, 8'hf0, 8'hcc, 8'haa, 8'h0f, 8'h00, 8'hff));
    send_item(make_decode(1'b0, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_item(make_decode(1'b0, 8'h96, 8'h3c, 8'he1, 8'h78, 8'haa, 8'hcc));
  endtask

  // held colour cleared before the first pixel of a frame-start item
  task automatic test_frame_start();
    send_item(make_decode(1'b0, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00));
    send_item(make_decode(1'b1, 8'h33, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00));
    send_item(make_write(4'd3, 8'h01, 8'h02, 8'h03, 1'b1));
    send_item(make_decode(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff));
  endtask

  // held colour carries over items and is untouched by writes in between
  task automatic test_hold_carry();
    send_item(make_decode(1'b0, 8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff));
    send_item(make_write(4'd0, 8'hee, 8'hdd, 8'hcc, 1'b0));
    send_item(make_decode(1'b0, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00));
    send_item(make_decode(1'b0, 8'h81, 8'h42, 8'h24, 8'h18, 8'h81, 8'h7e));
    drain_pixels();
  endtask

  task automatic test_random_traffic();
    item_t it;
    int    pick;
    for (int n = 0; n < RandomItems; n++) begin
      fast_mode = (n >= 40 && n < 70);
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        it = make_write(4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        1'($urandom));
      end else if (pick < 30) begin
        // sparse control: mostly table loads with an occasional modify
        it = make_decode($urandom_range(0, 7) == 0, 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom),
                         8'($urandom & $urandom), 8'($urandom & $urandom));
      end else begin
        it = make_decode($urandom_range(0, 7) == 0, 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      send_item(it);
      if (n == 60 || n == 90) drain_pixels();
    end
    fast_mode = 1'b0;
    drain_pixels();
  endtask

  initial begin
    for (int i = 0; i < TableDepth; i++) colour_table[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_table();
    test_table_write();
    test_each_control();
    test_frame_start();
    test_hold_carry();
    test_random_traffic();
    repeat (SettleCycles) @(posedge clk_i);
    if (pixel_q.size() != 0)
      report_mismatch($sformatf("%0d pixels never arrived", pixel_q.size()));
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side backpressure, drawn per pixel
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = fast_mode ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("pixel %0d with none pending", pixel_count));
      end else begin
        want_px = pixel_q.pop_front();
        if (out_red_o !== want_px.red)
          report_mismatch($sformatf("pixel %0d red %h want %h", pixel_count,
                                    out_red_o, want_px.red));
        if (out_green_o !== want_px.green)
          report_mismatch($sformatf("pixel %0d green %h want %h", pixel_count,
                                    out_green_o, want_px.green));
        if (out_blue_o !== want_px.blue)
          report_mismatch($sformatf("pixel %0d blue %h want %h", pixel_count,
                                    out_blue_o, want_px.blue));
        if (last_pixel_o !== want_px.last)
          report_mismatch($sformatf("pixel %0d last %b want %b", pixel_count,
                                    last_pixel_o, want_px.last));
      end
      pixel_count++;
    end
  end

  // watchdog: cycles without a transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ----- files.f -----
design/hmpd_pkg.sv
design/hmpd_palette.sv
design/hmpd_pixel.sv
design/hold_modify_pixel_decoder_unit.sv
dv/tb_hold_modify_pixel_decoder_unit.sv
